// File: hw/rtl/chld_pkg.sv
package chld_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLINK    = 2'd1;

  localparam logic [31:0] DEBOUNCE_RESET = 32'd200000;
  localparam logic [31:0] BLINK_RESET    = 32'd300000;

  typedef struct packed {
    logic        button_pressed;
    logic [31:0] now_us;
    logic [7:0]  picked_color;
  } item_t;

  typedef struct packed {
    logic                   valid;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } cfg_wr_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } levels_t;

  // 255 - (v * 255 / 7)
  function automatic logic [7:0] inv_expand3(input logic [2:0] v);
    logic [7:0] res;
    case (v)
      3'd0:    res = 8'd255;
      3'd1:    res = 8'd219;
      3'd2:    res = 8'd183;
      3'd3:    res = 8'd146;
      3'd4:    res = 8'd110;
      3'd5:    res = 8'd73;
      3'd6:    res = 8'd37;
      3'd7:    res = 8'd0;
      default: res = 8'd0;
    endcase
    return res;
  endfunction

  // 255 - (v * 255 / 3)
  function automatic logic [7:0] inv_expand2(input logic [1:0] v);
    logic [7:0] res;
    case (v)
      2'd0:    res = 8'd255;
      2'd1:    res = 8'd170;
      2'd2:    res = 8'd85;
      2'd3:    res = 8'd0;
      default: res = 8'd0;
    endcase
    return res;
  endfunction

endpackage

// File: hw/rtl/color_history_led_driver.sv
// Color history LED driver. Each request is one pass of the control loop:
// a debounced button press appends the RGB332 color to a history of
// HISTORY_DEPTH entries (oldest dropped when full), and the stored colors
// are shown in turn, one per blink interval, as inverted 8-bit PWM levels
// (all zero while the history is empty). Timing: an accepted request is
// held in the input register; its state update and color expansion then
// go into the result register once the output is free, raising out_valid.
// A new request is taken every cycle unless a stalled result holds the
// input register.
// Configuration: index 0 debounce interval, index 1 blink interval, both in
// microseconds; write only while no request is in flight.
module color_history_led_driver #(
  parameter int HISTORY_DEPTH = 3
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             button_pressed,
  input  logic [31:0]                      now_us,
  input  logic [7:0]                       picked_color,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       red_level,
  output logic [7:0]                       green_level,
  output logic [7:0]                       blue_level,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [chld_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [chld_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic              item_valid;
  chld_pkg::item_t   item;
  logic              out_free;
  logic              step;
  logic              shown;
  logic [7:0]        shown_color;
  chld_pkg::levels_t levels;
  chld_pkg::levels_t result;
  chld_pkg::cfg_wr_t cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr.valid = cfg_valid && cfg_ready;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  assign out_free = !out_valid || !out_stall;
  assign step     = item_valid && out_free;
  assign in_stall = item_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item.button_pressed <= button_pressed;
      item.now_us         <= now_us;
      item.picked_color   <= picked_color;
    end
  end

  chld_state #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_state (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr     (cfg_wr),
    .step       (step),
    .item       (item),
    .shown      (shown),
    .shown_color(shown_color)
  );

  chld_expand u_expand (
    .shown (shown),
    .color (shown_color),
    .levels(levels)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result <= levels;
    end
  end

  assign red_level   = result.red;
  assign green_level = result.green;
  assign blue_level  = result.blue;

endmodule

// File: hw/rtl/chld_expand.sv
module chld_expand (
  input  logic                 shown,
  input  logic [7:0]           color,
  output chld_pkg::levels_t    levels
);

  always_comb begin
    if (shown) begin
      levels.red   = chld_pkg::inv_expand3(color[7:5]);
      levels.green = chld_pkg::inv_expand3(color[4:2]);
      levels.blue  = chld_pkg::inv_expand2(color[1:0]);
    end else begin
      levels = '0;
    end
  end

endmodule

// File: hw/rtl/chld_state.sv
module chld_state #(
  parameter int HISTORY_DEPTH = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  chld_pkg::cfg_wr_t cfg_wr,
  input  logic              step,
  input  chld_pkg::item_t   item,
  output logic              shown,
  output logic [7:0]        shown_color
);

  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  logic [31:0] debounce_interval;
  logic [31:0] blink_interval;
  logic [7:0]  history [HISTORY_DEPTH];
  logic [7:0]  history_next [HISTORY_DEPTH];
  logic [CNT_W-1:0] stored_count, stored_count_next;
  logic [IDX_W-1:0] show_index, show_index_next;
  logic [31:0] last_press_time, last_press_time_next;
  logic [31:0] last_blink_time, last_blink_time_next;

  logic        press_ok;
  logic        blink_due;
  logic [IDX_W-1:0] idx_base;
  logic [CNT_W:0]   idx_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_interval <= chld_pkg::DEBOUNCE_RESET;
      blink_interval    <= chld_pkg::BLINK_RESET;
    end else if (cfg_wr.valid) begin
      if (cfg_wr.index == chld_pkg::CFG_DEBOUNCE) begin
        debounce_interval <= cfg_wr.data;
      end
      if (cfg_wr.index == chld_pkg::CFG_BLINK) begin
        blink_interval <= cfg_wr.data;
      end
    end
  end

  always_comb begin
    press_ok = item.button_pressed && ((item.now_us - last_press_time) > debounce_interval);
    history_next         = history;
    stored_count_next    = stored_count;
    last_press_time_next = last_press_time;
    if (press_ok) begin
      last_press_time_next = item.now_us;
      if (stored_count < CNT_W'(HISTORY_DEPTH)) begin
        history_next[stored_count[IDX_W-1:0]] = item.picked_color;
        stored_count_next = stored_count + 1'b1;
      end else begin
        for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
          history_next[i] = history[i+1];
        end
        history_next[HISTORY_DEPTH-1] = item.picked_color;
      end
    end

    shown = (stored_count_next != '0);
    idx_base = ({1'b0, show_index} >= (CNT_W+1)'(stored_count_next)) ? '0 : show_index;
    blink_due = (item.now_us - last_blink_time) > blink_interval;
    idx_inc = (CNT_W+1)'(idx_base) + 1'b1;
    show_index_next      = show_index;
    last_blink_time_next = last_blink_time;
    if (shown) begin
      show_index_next = idx_base;
      if (blink_due) begin
        last_blink_time_next = item.now_us;
        show_index_next = (idx_inc >= {1'b0, stored_count_next}) ? '0 : idx_inc[IDX_W-1:0];
      end
    end
    shown_color = history_next[show_index_next];
  end

  always_ff @(posedge clk) begin
    if (step) begin
      history <= history_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count    <= '0;
      show_index      <= '0;
      last_press_time <= '0;
      last_blink_time <= '0;
    end else if (step) begin
      stored_count    <= stored_count_next;
      show_index      <= show_index_next;
      last_press_time <= last_press_time_next;
      last_blink_time <= last_blink_time_next;
    end
  end

endmodule

// File: bench/color_history_led_driver_test.sv
module color_history_led_driver_test;

  localparam int DEPTH = 3;
  localparam logic [chld_pkg::CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [chld_pkg::CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

  class levels_scoreboard;
    logic [31:0] debounce_us;
    logic [31:0] blink_us;
    logic [7:0] history [DEPTH];
    int unsigned stored;
    int unsigned shown;
    logic [31:0] last_press_us;
    logic [31:0] last_blink_us;
    chld_pkg::levels_t expected_q [$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned requests;
    int unsigned presses;
    int unsigned color_steps;
    int unsigned reg_writes;

    function new();
      debounce_us = chld_pkg::DEBOUNCE_RESET;
      blink_us = chld_pkg::BLINK_RESET;
      foreach (history[i]) history[i] = 8'h00;
      stored = 0;
      shown = 0;
      last_press_us = '0;
      last_blink_us = '0;
      mismatches = 0;
      checked = 0;
      requests = 0;
      presses = 0;
      color_steps = 0;
      reg_writes = 0;
    endfunction

    function void set_register(logic [chld_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] value);
      reg_writes++;
      if (idx == chld_pkg::CFG_DEBOUNCE) debounce_us = value;
      else if (idx == chld_pkg::CFG_BLINK) blink_us = value;
    endfunction

    // inverted expansion of a channel with full scale top
    function logic [7:0] dim(int unsigned v, int unsigned top);
      logic [31:0] full;
      full = 255 - (v * 255) / top;
      return full[7:0];
    endfunction

    function void note_request(logic pressed, logic [31:0] now, logic [7:0] color);
      chld_pkg::levels_t lv;
      logic [7:0] cur;
      lv = '0;
      requests++;
      if (pressed && (now - last_press_us) > debounce_us) begin
        last_press_us = now;
        presses++;
        if (stored < DEPTH) begin
          history[stored] = color;
          stored++;
        end else begin
          for (int i = 1; i < DEPTH; i++) history[i-1] = history[i];
          history[DEPTH-1] = color;
        end
      end
      if (stored > 0) begin
        if (shown >= stored) shown = 0;
        if ((now - last_blink_us) > blink_us) begin
          last_blink_us = now;
          shown = (shown + 1 >= stored) ? 0 : shown + 1;
          color_steps++;
        end
        cur = history[shown];
        lv.red = dim(cur[7:5], 7);
        lv.green = dim(cur[4:2], 7);
        lv.blue = dim(cur[1:0], 3);
      end
      expected_q.push_back(lv);
    endfunction

    function void check_result(chld_pkg::levels_t got);
      chld_pkg::levels_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected levels r=%0d g=%0d b=%0d", $time,
                 got.red, got.green, got.blue);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got !== want) begin
        $display("%0t: levels expected r=%0d g=%0d b=%0d actual r=%0d g=%0d b=%0d",
                 $time, want.red, want.green, want.blue, got.red, got.green, got.blue);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic button_pressed = 1'b0;
  logic [31:0] now_us = '0;
  logic [7:0] picked_color = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] red_level;
  logic [7:0] green_level;
  logic [7:0] blue_level;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [chld_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [chld_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  levels_scoreboard sb = new();
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  logic [31:0] loop_us = '0;

  color_history_led_driver #(.HISTORY_DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .button_pressed(button_pressed),
    .now_us(now_us),
    .picked_color(picked_color),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .red_level(red_level),
    .green_level(green_level),
    .blue_level(blue_level),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_result('{red_level, green_level, blue_level});
      out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end
  end

  initial begin
    #3000000;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic send_request(logic pressed, logic [31:0] now, logic [7:0] color);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    button_pressed <= pressed;
    now_us <= now;
    picked_color <= color;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(pressed, now, color);
  endtask

  // hold off new requests until every pending result is back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_register(logic [chld_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(int count, int unsigned step_span, int unsigned idle_pct,
                           int unsigned stall_pct);
    int unsigned roll;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 75) loop_us = loop_us + $urandom_range(0, step_span);
      else if (roll < 88) loop_us = loop_us + $urandom_range(0, 2);
      else if (roll < 95) loop_us = $urandom();
      if ($urandom_range(0, 99) == 0) settle();
      send_request($urandom_range(0, 99) < 60, loop_us, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty history, debounce edge, then every channel code
    send_request(1'b0, 32'd0, 8'hFF);
    send_request(1'b1, 32'd200000, 8'hFF);
    send_request(1'b1, 32'd200001, 8'hFF);
    send_request(1'b1, 32'd200002, 8'h00);
    for (int k = 0; k < 8; k++)
      send_request(1'b1, 32'd400002 + k * 200001,
                   {3'(k), 3'(k), 2'(k)});
    send_request(1'b0, 32'hFFFF_FFFF, 8'h00);
    send_request(1'b1, 32'h0000_0010, 8'h5A);
    send_request(1'b1, 32'h0000_0011, 8'hA5);
    send_request(1'b0, 32'h7FFF_FFFF, 8'h00);
    send_request(1'b1, 32'h8000_0000, 8'hFF);
    loop_us = 32'h8000_0000;

    run_phase(300, 400000, 0, 0);

    settle();
    write_register(chld_pkg::CFG_DEBOUNCE, 32'd10);
    write_register(chld_pkg::CFG_BLINK, 32'd25);
    write_register(CFG_SPARE_A, $urandom());
    run_phase(350, 40, 75, 0);

    settle();
    write_register(chld_pkg::CFG_DEBOUNCE, 32'd0);
    write_register(chld_pkg::CFG_BLINK, 32'd0);
    run_phase(300, 3, 0, 75);

    settle();
    write_register(chld_pkg::CFG_DEBOUNCE, 32'hFFFF_FFFF);
    write_register(chld_pkg::CFG_BLINK, 32'hFFFF_FFFF);
    write_register(CFG_SPARE_B, $urandom());
    run_phase(100, 1000, 11, 11);

    settle();
    write_register(chld_pkg::CFG_DEBOUNCE, $urandom_range(0, 500));
    write_register(chld_pkg::CFG_BLINK, $urandom_range(0, 500));
    run_phase(400, 1000, 11, 11);

    settle();
    write_register(chld_pkg::CFG_DEBOUNCE, 32'd5);
    write_register(chld_pkg::CFG_BLINK, 32'd7);
    run_phase(400, 16, 0, 0);

    settle();
    repeat (8) @(posedge clk);

    $display("%0d requests, %0d results checked, %0d presses stored, %0d color steps",
             sb.requests, sb.checked, sb.presses, sb.color_steps);
    $display("%0d register writes, intervals from zero to all ones, mixed idle/stall",
             sb.reg_writes);
    if (sb.expected_q.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, sb.expected_q.size());
    if (sb.mismatches == 0 && sb.expected_q.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/chld_pkg.sv
hw/rtl/chld_expand.sv
hw/rtl/chld_state.sv
hw/rtl/color_history_led_driver.sv
bench/color_history_led_driver_test.sv
